// File: src/frame_diff_dirty_rect_macros.svh
// Assertion macros for the frame difference dirty rectangle detector.
`ifndef FRAME_DIFF_DIRTY_RECT_MACROS_SVH
`define FRAME_DIFF_DIRTY_RECT_MACROS_SVH

`ifndef SYNTHESIS
`define FDDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame_diff_dirty_rect: immediate check failed");
`define FDDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame_diff_dirty_rect: next cycle check failed");
`else
`define FDDR_ASSERT_NOW(lbl, ante, cons)
`define FDDR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/fddr_pkg.sv
// Types and constants shared by the dirty rectangle detector.
package fddr_pkg;

  localparam int unsigned FDDR_MAX_DIM = 4096;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd2;

  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [7:0]  RST_DIFF_THRESHOLD = 8'd8;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] first_alpha;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] second_alpha;
  } fddr_in_t;

  typedef struct packed {
    logic        changed;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } fddr_out_t;

endpackage

// File: src/frame_diff_dirty_rect.sv
// Top level of the frame difference dirty rectangle detector.
// Pixel pair beats are registered in s1_r, then processed from that register; the
// rectangle beat is registered in out_r when the last pixel of a frame advances.
// Throughput: one pixel pair per cycle, set by the min/max update; a frame end
// stalls the input only while the previous rectangle is still held by out_stall.
// Reset (synchronous, rst_n low) restores the register defaults, empties both
// pipeline registers and clears the frame tracking.
`include "frame_diff_dirty_rect_macros.svh"

module frame_diff_dirty_rect #(
  parameter int unsigned MAX_DIM = fddr_pkg::FDDR_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fddr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fddr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fddr_pkg::fddr_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fddr_pkg::fddr_out_t                 out_data
);
  import fddr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);

  logic [12:0]   frame_width_r;
  logic [12:0]   frame_height_r;
  logic [7:0]    diff_threshold_r;

  logic          s1_valid_r;
  fddr_in_t      s1_r;

  logic [CW-1:0] column_count_r, column_count_nxt;
  logic [CW-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0] min_column_r, min_column_nxt;
  logic [CW-1:0] max_column_r, max_column_nxt;
  logic [CW-1:0] min_row_r, min_row_nxt;
  logic [CW-1:0] max_row_r, max_row_nxt;
  logic          any_changed_r, any_changed_nxt;

  logic          out_valid_r;
  fddr_out_t     out_r, out_nxt;

  logic [9:0]    sum_first, sum_second;
  logic [7:0]    avg_first, avg_second, mag;
  logic          pix_changed;
  logic [CW-1:0] last_col, last_row;
  logic          row_end, frame_end;
  logic          advance, in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= RST_FRAME_WIDTH;
      frame_height_r   <= RST_FRAME_HEIGHT;
      diff_threshold_r <= RST_DIFF_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[12:0];
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata[12:0];
        CFG_DIFF_THRESHOLD: diff_threshold_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to the range one to MAX_DIM and take the last index.
  function automatic logic [CW-1:0] last_index(input logic [12:0] dim);
    logic [31:0] d;
    d = 32'(dim);
    if (d == 32'd0) begin
      return '0;
    end else if (d > 32'(MAX_DIM)) begin
      return CW'(MAX_DIM - 1);
    end else begin
      return CW'(d - 32'd1);
    end
  endfunction

  always_comb begin
    sum_first  = 10'(s1_r.first_red) + 10'(s1_r.first_green)
               + 10'(s1_r.first_blue) + 10'(s1_r.first_alpha);
    sum_second = 10'(s1_r.second_red) + 10'(s1_r.second_green)
               + 10'(s1_r.second_blue) + 10'(s1_r.second_alpha);
    avg_first   = sum_first[9:2];
    avg_second  = sum_second[9:2];
    mag         = (avg_first >= avg_second) ? (avg_first - avg_second)
                                            : (avg_second - avg_first);
    pix_changed = (mag >= diff_threshold_r);
    last_col    = last_index(frame_width_r);
    last_row    = last_index(frame_height_r);
    row_end     = (column_count_r >= last_col);
    frame_end   = row_end && (row_count_r >= last_row);
  end

  assign advance   = s1_valid_r && (!frame_end || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Bounding box update and frame position tracking.
  always_comb begin
    min_column_nxt   = min_column_r;
    max_column_nxt   = max_column_r;
    min_row_nxt      = min_row_r;
    max_row_nxt      = max_row_r;
    any_changed_nxt  = any_changed_r;
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (pix_changed) begin
      if (!any_changed_r || column_count_r < min_column_r) min_column_nxt = column_count_r;
      if (!any_changed_r || column_count_r > max_column_r) max_column_nxt = column_count_r;
      if (!any_changed_r || row_count_r < min_row_r)       min_row_nxt    = row_count_r;
      if (!any_changed_r || row_count_r > max_row_r)       max_row_nxt    = row_count_r;
      any_changed_nxt = 1'b1;
    end

    if (any_changed_nxt) begin
      out_nxt.changed     = 1'b1;
      out_nxt.rect_x      = 12'(32'(min_column_nxt));
      out_nxt.rect_y      = 12'(32'(min_row_nxt));
      out_nxt.rect_width  = 13'(32'(max_column_nxt) - 32'(min_column_nxt) + 32'd1);
      out_nxt.rect_height = 13'(32'(max_row_nxt) - 32'(min_row_nxt) + 32'd1);
    end else begin
      out_nxt = '0;
    end

    if (frame_end) begin
      column_count_nxt = '0;
      row_count_nxt    = '0;
      min_column_nxt   = '1;
      max_column_nxt   = '0;
      min_row_nxt      = '1;
      max_row_nxt      = '0;
      any_changed_nxt  = 1'b0;
    end else if (row_end) begin
      column_count_nxt = '0;
      row_count_nxt    = row_count_r + CW'(1);
    end else begin
      column_count_nxt = column_count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      column_count_r <= '0;
      row_count_r    <= '0;
      min_column_r   <= '1;
      max_column_r   <= '0;
      min_row_r      <= '1;
      max_row_r      <= '0;
      any_changed_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        column_count_r <= column_count_nxt;
        row_count_r    <= row_count_nxt;
        min_column_r   <= min_column_nxt;
        max_column_r   <= max_column_nxt;
        min_row_r      <= min_row_nxt;
        max_row_r      <= max_row_nxt;
        any_changed_r  <= any_changed_nxt;
      end

      if (advance && frame_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
    if (advance && frame_end) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FDDR_ASSERT_NOW(a_empty_rect_zero, out_valid_r && !out_r.changed, out_r.rect_x == 12'd0 && out_r.rect_y == 12'd0 && out_r.rect_width == 13'd0 && out_r.rect_height == 13'd0)
  `FDDR_ASSERT_NOW(a_changed_rect_size, out_valid_r && out_r.changed, out_r.rect_width != 13'd0 && out_r.rect_height != 13'd0)
  `FDDR_ASSERT_NOW(a_idle_box_cleared, !any_changed_r, min_column_r == '1 && max_column_r == '0 && min_row_r == '1 && max_row_r == '0)
  `FDDR_ASSERT_NEXT(a_out_held_on_stall, out_valid_r && out_stall, out_valid_r && $stable(out_r))

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the frame difference dirty rectangle detector.
module tb_top;
  import fddr_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int PRINT_LIMIT  = 40;

  typedef enum int {PAIR_RANDOM, PAIR_SAME, PAIR_NEAR, PAIR_RAIL} pair_style_t;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BURSTY} stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  fddr_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fddr_out_t             out_data;

  frame_diff_dirty_rect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fddr_in_t  pixel_q[$];
  fddr_out_t rect_expect_q[$];
  int        pixels_sent = 0;
  int        pixels_taken = 0;
  int        rects_predicted = 0;
  int        mismatch_count = 0;
  logic      in_took = 1'b0;

  logic [12:0] cur_width = RST_FRAME_WIDTH;
  logic [12:0] cur_height = RST_FRAME_HEIGHT;
  logic [7:0]  cur_threshold = RST_DIFF_THRESHOLD;
  logic [11:0] col_pos, row_pos;
  logic [11:0] box_min_col, box_max_col, box_min_row, box_max_row;
  logic        any_hit;

  function automatic void clear_tracking();
    col_pos = '0;
    row_pos = '0;
    box_min_col = '1;
    box_max_col = '0;
    box_min_row = '1;
    box_max_row = '0;
    any_hit = 1'b0;
  endfunction

  function automatic logic [11:0] last_index(logic [12:0] dim);
    if (dim == 13'd0) return 12'd0;
    if (dim > 13'(FDDR_MAX_DIM)) return 12'(FDDR_MAX_DIM - 1);
    return 12'(dim - 13'd1);
  endfunction

  function automatic void predict_pixel(fddr_in_t px);
    logic [9:0]  sum_first, sum_second;
    logic [7:0]  avg_first, avg_second, mag;
    logic [11:0] last_col, last_row;
    logic        row_end;
    fddr_out_t   rect;
    sum_first = 10'(px.first_red) + 10'(px.first_green) + 10'(px.first_blue)
              + 10'(px.first_alpha);
    sum_second = 10'(px.second_red) + 10'(px.second_green) + 10'(px.second_blue)
               + 10'(px.second_alpha);
    avg_first = sum_first[9:2];
    avg_second = sum_second[9:2];
    mag = (avg_first >= avg_second) ? avg_first - avg_second : avg_second - avg_first;
    last_col = last_index(cur_width);
    last_row = last_index(cur_height);
    if (mag >= cur_threshold) begin
      if (!any_hit || col_pos < box_min_col) box_min_col = col_pos;
      if (!any_hit || col_pos > box_max_col) box_max_col = col_pos;
      if (!any_hit || row_pos < box_min_row) box_min_row = row_pos;
      if (!any_hit || row_pos > box_max_row) box_max_row = row_pos;
      any_hit = 1'b1;
    end
    row_end = col_pos >= last_col;
    if (row_end && row_pos >= last_row) begin
      rect = '0;
      if (any_hit) begin
        rect.changed = 1'b1;
        rect.rect_x = box_min_col;
        rect.rect_y = box_min_row;
        rect.rect_width = {1'b0, box_max_col} - {1'b0, box_min_col} + 13'd1;
        rect.rect_height = {1'b0, box_max_row} - {1'b0, box_min_row} + 13'd1;
      end
      rect_expect_q.insert(rect_expect_q.size(), rect);
      rects_predicted++;
      clear_tracking();
    end else if (row_end) begin
      col_pos = '0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : rect_monitor
    fddr_out_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      predict_pixel(in_data);
      pixels_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (rect_expect_q.size() == 0) begin
        report_mismatch("result beat with no rectangle pending");
      end else begin
        want = rect_expect_q.pop_front();
        if (out_data.changed !== want.changed)
          report_mismatch($sformatf("changed %0b, wanted %0b", out_data.changed, want.changed));
        if (out_data.rect_x !== want.rect_x)
          report_mismatch($sformatf("rect_x %0d, wanted %0d", out_data.rect_x, want.rect_x));
        if (out_data.rect_y !== want.rect_y)
          report_mismatch($sformatf("rect_y %0d, wanted %0d", out_data.rect_y, want.rect_y));
        if (out_data.rect_width !== want.rect_width)
          report_mismatch($sformatf("rect_width %0d, wanted %0d",
                                    out_data.rect_width, want.rect_width));
        if (out_data.rect_height !== want.rect_height)
          report_mismatch($sformatf("rect_height %0d, wanted %0d",
                                    out_data.rect_height, want.rect_height));
      end
    end
  end

  int   gap_left = 0;
  int   burst_left = 0;
  logic drain_hold = 1'b0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() == 0 || (drain_hold && rect_expect_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        drain_hold = 1'b0;
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          drain_hold = ($urandom_range(0, 24) == 0);
        end
      end
    end
  end

  stall_style_t stall_style = STALL_NONE;
  int           stall_span = 0;
  int           stall_run = 0;
  int           stall_tick = 0;

  always @(negedge clk) begin : result_stall
    logic next_stall;
    if (stall_span == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 128);
    end
    stall_span--;
    stall_tick++;
    case (stall_style)
      STALL_NONE: next_stall = 1'b0;
      STALL_COIN: next_stall = ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: next_stall = (stall_tick % 5) < 2;
      default: begin
        if (stall_run != 0) begin
          stall_run--;
          next_stall = 1'b1;
        end else begin
          next_stall = 1'b0;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(4, 12);
        end
      end
    endcase
    out_stall <= next_stall;
  end

  function automatic int byte_sum(logic [31:0] word);
    return int'(word[31:24]) + int'(word[23:16]) + int'(word[15:8]) + int'(word[7:0]);
  endfunction

  function automatic logic [31:0] spread_sum(int total);
    logic [31:0] word;
    int rest, lo, hi, c;
    rest = total;
    for (int i = 3; i >= 0; i--) begin
      lo = rest - 255 * i;
      if (lo < 0) lo = 0;
      hi = (rest > 255) ? 255 : rest;
      c = int'($urandom_range(hi, lo));
      word[i*8 +: 8] = 8'(c);
      rest -= c;
    end
    return word;
  endfunction

  function automatic fddr_in_t make_pair(pair_style_t style);
    logic [31:0] first_px, second_px;
    logic [63:0] rail;
    int target;
    first_px = $urandom;
    second_px = $urandom;
    case (style)
      PAIR_SAME: second_px = first_px;
      PAIR_NEAR: begin
        target = 4 * (int'(cur_threshold) + int'($urandom_range(0, 4)) - 2)
               + int'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) target = -target;
        target += byte_sum(first_px);
        if (target < 0) target = 0;
        if (target > 1020) target = 1020;
        second_px = spread_sum(target);
      end
      PAIR_RAIL: begin
        for (int i = 0; i < 8; i++) rail[i*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return rail;
      end
      default: ;
    endcase
    return {first_px, second_px};
  endfunction

  task automatic push_pixel(input fddr_in_t px);
    pixel_q.insert(pixel_q.size(), px);
    pixels_sent++;
  endtask

  task automatic push_pixels(input int count, input int active_pct);
    pair_style_t style;
    for (int i = 0; i < count; i++) begin
      style = PAIR_SAME;
      if (int'($urandom_range(0, 99)) < active_pct)
        style = pair_style_t'($urandom_range(0, 3));
      push_pixel(make_pair(style));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: cur_width = wdata;
      CFG_FRAME_HEIGHT: cur_height = wdata;
      CFG_DIFF_THRESHOLD: cur_threshold = wdata[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixels_taken != pixels_sent || rect_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] w, h, t;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = 13'd1;
      2: w = 13'($urandom_range(9, 40));
      default: w = 13'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 7))
      0: h = '0;
      1: h = 13'd1;
      default: h = 13'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 19))
      0, 1: t = '0;
      2: t = 13'd255;
      3, 4: t = 13'($urandom_range(1, 255));
      default: t = 13'($urandom_range(1, 12));
    endcase
    if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_WIDTH, w);
    if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_HEIGHT, h);
    if ($urandom_range(0, 2) != 0) write_reg(CFG_DIFF_THRESHOLD, t);
  endtask

  initial begin : stimulus
    int frames, count, random_pixels, active_pct;
    random_pixels = 0;
    clear_tracking();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults, the channel extremes and averages either side of the threshold.
    push_pixel({32'h00000000, 32'hFFFFFFFF});
    push_pixel({32'hFFFFFFFF, 32'h00000000});
    push_pixel({32'h07070707, 32'h00000000});
    push_pixel({32'h00000000, 32'h08080808});
    push_pixel({32'h0B0B0B0C, 32'h03030304});
    push_pixel({32'h12345678, 32'h12345678});
    push_pixel({32'h80808080, 32'h7F7F7F7F});
    push_pixel({32'hFF00FF00, 32'h00FF00FF});
    wait_idle();

    // Settings changed part way through a frame, with a zero threshold.
    write_reg(CFG_FRAME_WIDTH, 13'd5);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    write_reg(CFG_DIFF_THRESHOLD, 13'd0);
    push_pixels(6, 100);
    wait_idle();

    // Zero dimensions act as one pixel per frame; the highest threshold.
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    write_reg(CFG_DIFF_THRESHOLD, 13'd255);
    push_pixel({32'h00000000, 32'hFFFFFFFF});
    push_pixel({32'hFFFFFFFF, 32'h00000000});
    push_pixel({32'hFFFFFFFF, 32'h00000004});
    wait_idle();

    // An unchanged frame, then one whose only change is its last pixel.
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    write_reg(CFG_DIFF_THRESHOLD, 13'd1);
    push_pixels(4, 0);
    push_pixels(3, 0);
    push_pixel({32'h80808080, 32'h7F7F7F7F});
    wait_idle();

    // An oversized width keeps the row open; narrowing it part way along ends the frame.
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    write_reg(CFG_DIFF_THRESHOLD, 13'd8);
    push_pixel({32'h00000000, 32'hFFFFFFFF});
    push_pixels(38, 30);
    push_pixel({32'hFFFFFFFF, 32'h00000000});
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd40);
    push_pixel({32'h12345678, 32'h12345678});
    wait_idle();

    while (random_pixels < 1000 || rects_predicted < 60) begin
      random_settings();
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        count = (int'(last_index(cur_width)) + 1) * (int'(last_index(cur_height)) + 1);
        if (f == frames - 1 && $urandom_range(0, 5) == 0) count = $urandom_range(1, count);
        case ($urandom_range(0, 3))
          0: active_pct = 0;
          1: active_pct = 5;
          2: active_pct = 30;
          default: active_pct = 100;
        endcase
        push_pixels(count, active_pct);
        random_pixels += count;
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
